/* hw/rtl/gcsm_pkg.sv */
// ============================================================================
// gcsm_pkg: shared definitions for the grid cell shape membership core
// Widths, shape, register and mark codes, and the pipeline stage words.
// ============================================================================
package gcsm_pkg;

  localparam int GRID_SIDE = 64;
  localparam int VALUE_BITS = 32;
  localparam int COORD_W = $clog2(GRID_SIDE);
  localparam int VALUE_W = VALUE_BITS;
  localparam int CFG_IDX_W = 3;
  localparam int KIND_W = 4;
  localparam int MARK_W = 2;
  localparam int SQ_W = 2 * COORD_W;
  localparam int PROD_W = 2 * SQ_W;

  // Shape kinds.
  localparam logic [KIND_W-1:0] KIND_CIRCLE   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_HALF_N   = 4'd1;
  localparam logic [KIND_W-1:0] KIND_HALF_S   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_HALF_E   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_HALF_W   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_RECT     = 4'd5;
  localparam logic [KIND_W-1:0] KIND_TRIANGLE = 4'd6;
  localparam logic [KIND_W-1:0] KIND_ELLIPSE  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_INACCESS = 4'd8;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_KIND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CX_X1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CY_X2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_R_Y1       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXTRA_Y2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_X     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Y     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FILL       = 3'd7;

  // Mark codes.
  localparam logic [MARK_W-1:0] MARK_NONE         = 2'd0;
  localparam logic [MARK_W-1:0] MARK_BOUNDARY     = 2'd1;
  localparam logic [MARK_W-1:0] MARK_INACCESSIBLE = 2'd2;

  localparam logic [COORD_W-1:0] GRID_LAST_RESET = COORD_W'(50);

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [KIND_W-1:0]  kind;
    logic               fits;
    logic               half_ok;
    logic               span_in;
    logic               tri_degen;
    logic               ell_degen;
    logic [COORD_W-1:0] dx_abs;
    logic [COORD_W-1:0] dy_abs;
    logic [COORD_W-1:0] tri_w;
    logic [COORD_W-1:0] tri_t;
    logic [COORD_W-1:0] tri_h;
    logic [COORD_W-1:0] tri_d;
  } s1_t;

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [KIND_W-1:0]  kind;
    logic               fits;
    logic               half_ok;
    logic               span_in;
    logic               tri_degen;
    logic               ell_degen;
    logic [SQ_W-1:0]    dx2;
    logic [SQ_W-1:0]    dy2;
    logic [SQ_W-1:0]    r2;
    logic [SQ_W-1:0]    ry2;
    logic [SQ_W-1:0]    tri_lhs;
    logic [SQ_W-1:0]    tri_rhs;
  } s2_t;

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [KIND_W-1:0]  kind;
    logic               fits;
    logic               half_ok;
    logic               span_in;
    logic               tri_degen;
    logic               ell_degen;
    logic               cir_in;
    logic               tri_in;
    logic [PROD_W-1:0]  ell_x;
    logic [PROD_W-1:0]  ell_y;
    logic [PROD_W-1:0]  ell_r;
  } s3_t;

endpackage

/* hw/rtl/grid_cell_shape_membership_core.sv */
// ============================================================================
// grid_cell_shape_membership_core: shape coverage test for grid cells
// Four-stage pipeline: one cell per cycle unless stalled, vs. configured shape.
// ============================================================================
// Four register stages, s1, s2, s3 and the output register, which a result
// word passes in that order. One word per cycle for every shape while the
// result channel does not stall, set by the squaring stage and the 12 by 12
// bit ellipse product stage, each with its own register. Reset clears the
// valid bits and sets config to grid last index 50, all else zero.
module grid_cell_shape_membership_core
  import gcsm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]   cfg_data,
  // Cell input channel.
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COORD_W-1:0]   cell_x,
  input  logic [COORD_W-1:0]   cell_y,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COORD_W-1:0]   out_x,
  output logic [COORD_W-1:0]   out_y,
  output logic [MARK_W-1:0]    mark,
  output logic signed [VALUE_W-1:0] write_value,
  output logic                 shape_fits
);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; the user writes them
  // only while no word is in flight, so every stage may read them directly.
  // --------------------------------------------------------------------------
  logic [KIND_W-1:0]         shape_kind;
  logic [COORD_W-1:0]        reg_a;
  logic [COORD_W-1:0]        reg_b;
  logic [COORD_W-1:0]        reg_c;
  logic [COORD_W-1:0]        reg_d;
  logic [COORD_W-1:0]        grid_x_last;
  logic [COORD_W-1:0]        grid_y_last;
  logic signed [VALUE_W-1:0] fill_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_kind  <= KIND_CIRCLE;
      reg_a       <= '0;
      reg_b       <= '0;
      reg_c       <= '0;
      reg_d       <= '0;
      grid_x_last <= GRID_LAST_RESET;
      grid_y_last <= GRID_LAST_RESET;
      fill_value  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SHAPE_KIND: shape_kind  <= cfg_data[KIND_W-1:0];
        REG_CX_X1:      reg_a       <= cfg_data[COORD_W-1:0];
        REG_CY_X2:      reg_b       <= cfg_data[COORD_W-1:0];
        REG_R_Y1:       reg_c       <= cfg_data[COORD_W-1:0];
        REG_EXTRA_Y2:   reg_d       <= cfg_data[COORD_W-1:0];
        REG_GRID_X:     grid_x_last <= cfg_data[COORD_W-1:0];
        REG_GRID_Y:     grid_y_last <= cfg_data[COORD_W-1:0];
        REG_FILL:       fill_value  <= cfg_data;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. Each stage loads when it is empty or its word moves on, so
  // bubbles close up and a waiting result blocks earlier stages only once
  // every stage behind it is full.
  // --------------------------------------------------------------------------
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) out_valid <= v3;
    end
  end

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] p,
                                                  input logic [COORD_W-1:0] q);
    abs_diff = (p >= q) ? p - q : q - p;
  endfunction

  // --------------------------------------------------------------------------
  // Stage 1: offsets, spans and the fit check.
  // --------------------------------------------------------------------------
  s1_t s1, s1_next;
  logic [COORD_W:0]   a_plus_c, b_plus_c, b_plus_d, a_plus_b;
  logic [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi, tri_xc;
  logic               dx_neg, dx_zero, dy_neg, dy_zero;

  always_comb begin
    a_plus_c = {1'b0, reg_a} + {1'b0, reg_c};
    b_plus_c = {1'b0, reg_b} + {1'b0, reg_c};
    b_plus_d = {1'b0, reg_b} + {1'b0, reg_d};
    a_plus_b = {1'b0, reg_a} + {1'b0, reg_b};
    x_lo     = (reg_a < reg_b) ? reg_a : reg_b;
    x_hi     = (reg_a < reg_b) ? reg_b : reg_a;
    y_lo     = (reg_c < reg_d) ? reg_c : reg_d;
    y_hi     = (reg_c < reg_d) ? reg_d : reg_c;
    tri_xc   = a_plus_b[COORD_W:1];
    dx_neg   = cell_x < reg_a;
    dx_zero  = cell_x == reg_a;
    dy_neg   = cell_y < reg_b;
    dy_zero  = cell_y == reg_b;

    s1_next.cx        = cell_x;
    s1_next.cy        = cell_y;
    s1_next.kind      = shape_kind;
    s1_next.dx_abs    = abs_diff(cell_x, reg_a);
    s1_next.dy_abs    = abs_diff(cell_y, reg_b);
    s1_next.span_in   = (cell_x >= x_lo) && (cell_x <= x_hi) &&
                        (cell_y >= y_lo) && (cell_y <= y_hi);
    s1_next.tri_w     = abs_diff(reg_a, reg_b);
    s1_next.tri_h     = abs_diff(reg_c, reg_d);
    s1_next.tri_d     = abs_diff(cell_x, tri_xc);
    // The row term is exact whenever the cell lies in the span, which is the
    // only case in which the triangle compare counts.
    s1_next.tri_t     = (reg_d > reg_c) ? reg_d - cell_y : cell_y - reg_d;
    s1_next.tri_degen = (reg_a == reg_b) || (reg_c == reg_d);
    s1_next.ell_degen = (reg_c == '0) || (reg_d == '0);

    unique case (shape_kind)
      KIND_HALF_N: s1_next.half_ok = !dy_neg;
      KIND_HALF_S: s1_next.half_ok = dy_neg || dy_zero;
      KIND_HALF_E: s1_next.half_ok = !dx_neg;
      KIND_HALF_W: s1_next.half_ok = dx_neg || dx_zero;
      default:     s1_next.half_ok = 1'b1;
    endcase

    // A half circle only loses extent on the side that it cuts away.
    unique case (shape_kind)
      KIND_CIRCLE, KIND_HALF_N, KIND_HALF_S, KIND_HALF_E, KIND_HALF_W,
      KIND_INACCESS: begin
        s1_next.fits =
          (shape_kind == KIND_HALF_E || reg_a >= reg_c) &&
          ((shape_kind == KIND_HALF_W) ? (reg_a <= grid_x_last)
                                       : (a_plus_c <= {1'b0, grid_x_last})) &&
          (shape_kind == KIND_HALF_N || reg_b >= reg_c) &&
          ((shape_kind == KIND_HALF_S) ? (reg_b <= grid_y_last)
                                       : (b_plus_c <= {1'b0, grid_y_last}));
      end
      KIND_RECT, KIND_TRIANGLE: begin
        s1_next.fits = (reg_a <= grid_x_last) && (reg_b <= grid_x_last) &&
                       (reg_c <= grid_y_last) && (reg_d <= grid_y_last);
      end
      KIND_ELLIPSE: begin
        s1_next.fits = (reg_a >= reg_c) && (reg_b >= reg_d) &&
                       (a_plus_c <= {1'b0, grid_x_last}) &&
                       (b_plus_d <= {1'b0, grid_y_last});
      end
      default: s1_next.fits = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) s1 <= s1_next;
  end

  // --------------------------------------------------------------------------
  // Stage 2: squares and the triangle's two products, all 6 by 6 bits.
  // --------------------------------------------------------------------------
  s2_t s2_next, s2;

  always_comb begin
    s2_next.cx        = s1.cx;
    s2_next.cy        = s1.cy;
    s2_next.kind      = s1.kind;
    s2_next.fits      = s1.fits;
    s2_next.half_ok   = s1.half_ok;
    s2_next.span_in   = s1.span_in;
    s2_next.tri_degen = s1.tri_degen;
    s2_next.ell_degen = s1.ell_degen;
    s2_next.dx2       = SQ_W'(s1.dx_abs) * SQ_W'(s1.dx_abs);
    s2_next.dy2       = SQ_W'(s1.dy_abs) * SQ_W'(s1.dy_abs);
    s2_next.r2        = SQ_W'(reg_c) * SQ_W'(reg_c);
    s2_next.ry2       = SQ_W'(reg_d) * SQ_W'(reg_d);
    s2_next.tri_lhs   = SQ_W'(s1.tri_w) * SQ_W'(s1.tri_t);
    s2_next.tri_rhs   = SQ_W'(s1.tri_h) * SQ_W'(s1.tri_d);
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) s2 <= s2_next;
  end

  // --------------------------------------------------------------------------
  // Stage 3: circle and triangle compares, ellipse cross products.
  // The ellipse x radius squared equals the circle radius squared.
  // --------------------------------------------------------------------------
  s3_t s3_next, s3;

  always_comb begin
    s3_next.cx        = s2.cx;
    s3_next.cy        = s2.cy;
    s3_next.kind      = s2.kind;
    s3_next.fits      = s2.fits;
    s3_next.half_ok   = s2.half_ok;
    s3_next.span_in   = s2.span_in;
    s3_next.tri_degen = s2.tri_degen;
    s3_next.ell_degen = s2.ell_degen;
    s3_next.cir_in    = ({1'b0, s2.dx2} + {1'b0, s2.dy2}) < {1'b0, s2.r2};
    s3_next.tri_in    = {1'b0, s2.tri_lhs} >= {s2.tri_rhs, 1'b0};
    s3_next.ell_x     = PROD_W'(s2.dx2) * PROD_W'(s2.ry2);
    s3_next.ell_y     = PROD_W'(s2.dy2) * PROD_W'(s2.r2);
    s3_next.ell_r     = PROD_W'(s2.r2) * PROD_W'(s2.ry2);
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) s3 <= s3_next;
  end

  // --------------------------------------------------------------------------
  // Stage 4: ellipse sum compare, mark selection and the output register.
  // --------------------------------------------------------------------------
  logic              ell_in;
  logic [MARK_W-1:0] mark_next;

  always_comb begin
    ell_in = ({1'b0, s3.ell_x} + {1'b0, s3.ell_y}) <= {1'b0, s3.ell_r};
    unique case (s3.kind)
      KIND_CIRCLE, KIND_HALF_N, KIND_HALF_S, KIND_HALF_E, KIND_HALF_W: begin
        mark_next = (s3.fits && s3.cir_in && s3.half_ok) ? MARK_BOUNDARY : MARK_NONE;
      end
      KIND_INACCESS: begin
        mark_next = (s3.fits && s3.cir_in) ? MARK_INACCESSIBLE : MARK_NONE;
      end
      KIND_RECT: begin
        mark_next = (s3.fits && s3.span_in) ? MARK_BOUNDARY : MARK_NONE;
      end
      KIND_TRIANGLE: begin
        mark_next = (s3.fits && s3.span_in && !s3.tri_degen && s3.tri_in)
                    ? MARK_BOUNDARY : MARK_NONE;
      end
      KIND_ELLIPSE: begin
        mark_next = (s3.fits && !s3.ell_degen && ell_in) ? MARK_BOUNDARY : MARK_NONE;
      end
      default: mark_next = MARK_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      out_x       <= s3.cx;
      out_y       <= s3.cy;
      mark        <= mark_next;
      write_value <= (mark_next != MARK_NONE) ? fill_value : '0;
      shape_fits  <= s3.fits;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // An accepted word always lands in the first stage.
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted word did not enter stage one");

  // A covered cell implies a shape that fits the grid.
  a_mark_fits: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mark != MARK_NONE) |-> shape_fits)
    else $error("cell marked although the shape does not fit");

  // Only the inaccessible circle produces the inaccessible mark.
  a_inaccess_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mark == MARK_INACCESSIBLE) |-> (shape_kind == KIND_INACCESS))
    else $error("inaccessible mark from another shape kind");

  // A result waiting at the output keeps its payload while later words advance.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(mark) && $stable(write_value))
    else $error("stalled result changed");

endmodule

/* tb/gcsm_cover_checker.sv */
// ============================================================================
// gcsm_cover_checker: result predictor and scoreboard for the shape core
// Tracks register writes, predicts one result word per accepted cell word and
// compares every accepted result word against the oldest prediction.
// ============================================================================
module gcsm_cover_checker
  import gcsm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [VALUE_W-1:0]        cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [COORD_W-1:0]        cell_x,
  input  logic [COORD_W-1:0]        cell_y,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [COORD_W-1:0]        out_x,
  input  logic [COORD_W-1:0]        out_y,
  input  logic [MARK_W-1:0]         mark,
  input  logic signed [VALUE_W-1:0] write_value,
  input  logic                      shape_fits,
  output int                        fault_count,
  output int                        outstanding
);

  // Far more slots than the pipeline can ever hold in flight.
  localparam int EXP_DEPTH = 16;
  localparam int EXP_PTR_W = $clog2(EXP_DEPTH);

  typedef struct packed {
    logic [COORD_W-1:0]        x;
    logic [COORD_W-1:0]        y;
    logic [MARK_W-1:0]         mark;
    logic signed [VALUE_W-1:0] value;
    logic                      fits;
  } cell_word_t;

  logic [KIND_W-1:0]         cur_kind;
  logic [COORD_W-1:0]        cur_x1, cur_x2, cur_y1, cur_y2, cur_gx, cur_gy;
  logic signed [VALUE_W-1:0] cur_fill;
  cell_word_t                expected_cells [EXP_DEPTH];
  logic [EXP_PTR_W-1:0]      exp_wr, exp_rd;
  int                        exp_count;

  // Exact integer coverage test for the current shape settings.
  function automatic cell_word_t cover_cell(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    int a, b, c, d, gx, gy, px, py, dx, dy, xlo, xhi, ylo, yhi, w, xc, dd;
    bit fits, hit;
    cell_word_t res;
    a = cur_x1;
    b = cur_x2;
    c = cur_y1;
    d = cur_y2;
    gx = cur_gx;
    gy = cur_gy;
    px = x;
    py = y;
    dx = px - a;
    dy = py - b;
    fits = 1'b1;
    hit = 1'b0;
    if (cur_kind <= KIND_HALF_W || cur_kind == KIND_INACCESS) begin
      // A half circle only loses extent on the side it cuts away.
      xlo = (cur_kind == KIND_HALF_E) ? a : a - c;
      xhi = (cur_kind == KIND_HALF_W) ? a : a + c;
      ylo = (cur_kind == KIND_HALF_N) ? b : b - c;
      yhi = (cur_kind == KIND_HALF_S) ? b : b + c;
      fits = xlo >= 0 && xhi <= gx && ylo >= 0 && yhi <= gy;
      hit = fits && (dx * dx + dy * dy < c * c);
      case (cur_kind)
        KIND_HALF_N: hit = hit && dy >= 0;
        KIND_HALF_S: hit = hit && dy <= 0;
        KIND_HALF_E: hit = hit && dx >= 0;
        KIND_HALF_W: hit = hit && dx <= 0;
        default: ;
      endcase
    end else if (cur_kind == KIND_RECT || cur_kind == KIND_TRIANGLE) begin
      fits = a <= gx && b <= gx && c <= gy && d <= gy;
      hit = fits && px >= (a < b ? a : b) && px <= (a > b ? a : b) &&
            py >= (c < d ? c : d) && py <= (c > d ? c : d);
      if (cur_kind == KIND_TRIANGLE) begin
        w = (a > b) ? a - b : b - a;
        xc = (a + b) / 2;
        dd = (px > xc) ? px - xc : xc - px;
        if (w == 0 || c == d) begin
          hit = 1'b0;
        end else if (d > c) begin
          hit = hit && (w * (d - py) >= 2 * (d - c) * dd);
        end else begin
          hit = hit && (w * (py - d) >= 2 * (c - d) * dd);
        end
      end
    end else if (cur_kind == KIND_ELLIPSE) begin
      fits = a - c >= 0 && b - d >= 0 && a + c <= gx && b + d <= gy;
      hit = fits && c != 0 && d != 0 &&
            (dx * dx * d * d + dy * dy * c * c <= c * c * d * d);
    end
    res.x = x;
    res.y = y;
    res.fits = fits;
    res.mark = !hit ? MARK_NONE :
               (cur_kind == KIND_INACCESS) ? MARK_INACCESSIBLE : MARK_BOUNDARY;
    res.value = hit ? cur_fill : '0;
    return res;
  endfunction

  // Everything is sampled on the falling edge before the edge that takes it,
  // when the channels are settled.
  always @(negedge clk) begin
    cell_word_t want;
    if (rst) begin
      cur_kind = KIND_CIRCLE;
      cur_x1 = '0;
      cur_x2 = '0;
      cur_y1 = '0;
      cur_y2 = '0;
      cur_gx = GRID_LAST_RESET;
      cur_gy = GRID_LAST_RESET;
      cur_fill = '0;
      exp_wr = '0;
      exp_rd = '0;
      exp_count = 0;
      fault_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SHAPE_KIND: cur_kind = cfg_data[KIND_W-1:0];
          REG_CX_X1:      cur_x1 = cfg_data[COORD_W-1:0];
          REG_CY_X2:      cur_x2 = cfg_data[COORD_W-1:0];
          REG_R_Y1:       cur_y1 = cfg_data[COORD_W-1:0];
          REG_EXTRA_Y2:   cur_y2 = cfg_data[COORD_W-1:0];
          REG_GRID_X:     cur_gx = cfg_data[COORD_W-1:0];
          REG_GRID_Y:     cur_gy = cfg_data[COORD_W-1:0];
          REG_FILL:       cur_fill = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (exp_count == EXP_DEPTH) begin
          $error("too many result words outstanding at cell (%0d,%0d)", cell_x, cell_y);
          fault_count++;
        end else begin
          expected_cells[exp_wr] = cover_cell(cell_x, cell_y);
          exp_wr = exp_wr + 1'b1;
          exp_count++;
        end
      end
      if (out_valid && out_ready) begin
        if (exp_count == 0) begin
          $error("unexpected result word for cell (%0d,%0d)", out_x, out_y);
          fault_count++;
        end else begin
          want = expected_cells[exp_rd];
          exp_rd = exp_rd + 1'b1;
          exp_count--;
          if (out_x !== want.x) begin
            $error("out_x: expected %0d, got %0d", want.x, out_x);
            fault_count++;
          end
          if (out_y !== want.y) begin
            $error("out_y: expected %0d, got %0d", want.y, out_y);
            fault_count++;
          end
          if (mark !== want.mark) begin
            $error("mark: expected %0d, got %0d", want.mark, mark);
            fault_count++;
          end
          if (write_value !== want.value) begin
            $error("write_value: expected %0d, got %0d", want.value, write_value);
            fault_count++;
          end
          if (shape_fits !== want.fits) begin
            $error("shape_fits: expected %0d, got %0d", want.fits, shape_fits);
            fault_count++;
          end
        end
      end
    end
    outstanding = exp_count;
  end

endmodule

/* tb/tb.sv */
// ============================================================================
// tb: stimulus and verdict for grid_cell_shape_membership_core
// Programs a series of shapes, streams cell words with random gaps and
// result back-pressure, and leaves prediction and comparison to the checker.
// ============================================================================
module tb;
  import gcsm_pkg::*;

  localparam int COORD_MAX   = GRID_SIDE - 1;
  localparam int DIRECTED    = 12;
  localparam int PHASES      = 16;
  localparam int PHASE_CELLS = 25;
  // Cycles without any accepted word before the run is declared hung. A
  // correct run never comes close: the pipeline is four deep and every stall
  // is a short random run.
  localparam int QUIET_LIMIT = 2000;

  // Shape kinds the core does not define; they must cover nothing.
  localparam logic [KIND_W-1:0] KIND_FIRST_UNUSED = 4'd9;
  localparam logic [KIND_W-1:0] KIND_LAST_UNUSED  = 4'd15;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] p1;
    logic [COORD_W-1:0] p2;
    logic [COORD_W-1:0] p3;
    logic [COORD_W-1:0] p4;
    logic [COORD_W-1:0] gx;
    logic [COORD_W-1:0] gy;
    logic [VALUE_W-1:0] fill;
  } shape_setup_t;

  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
  } probe_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VALUE_W-1:0]   cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic [COORD_W-1:0]   cell_x = '0;
  logic [COORD_W-1:0]   cell_y = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_ready, in_ready, out_valid, shape_fits;
  logic [COORD_W-1:0]   out_x, out_y;
  logic [MARK_W-1:0]    mark;
  logic signed [VALUE_W-1:0] write_value;

  int fault_count;
  int outstanding;
  int quiet_cycles = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  // Directed shapes: every kind once (the triangle twice), plus a circle that
  // does not fit and an undefined kind. Each shape gets two probe cells, each
  // near the shape, on a grid edge or at a grid corner.
  shape_setup_t directed_plan [DIRECTED] = '{
    '{KIND_CIRCLE,   6'd10, 6'd10, 6'd5,  6'd0,  6'd50, 6'd50, 32'h7fff_ffff},
    '{KIND_HALF_N,   6'd20, 6'd20, 6'd8,  6'd0,  6'd50, 6'd50, 32'h8000_0000},
    '{KIND_HALF_S,   6'd20, 6'd20, 6'd8,  6'd0,  6'd50, 6'd50, 32'h0001_0000},
    '{KIND_HALF_E,   6'd20, 6'd30, 6'd10, 6'd0,  6'd50, 6'd50, 32'hffff_8000},
    '{KIND_HALF_W,   6'd20, 6'd30, 6'd10, 6'd0,  6'd50, 6'd50, 32'h0000_0001},
    '{KIND_RECT,     6'd40, 6'd5,  6'd3,  6'd60, 6'd63, 6'd63, 32'hffff_ffff},
    '{KIND_TRIANGLE, 6'd10, 6'd30, 6'd5,  6'd25, 6'd50, 6'd50, 32'h1234_5678},
    '{KIND_TRIANGLE, 6'd30, 6'd10, 6'd40, 6'd20, 6'd50, 6'd50, 32'h8765_4321},
    '{KIND_ELLIPSE,  6'd30, 6'd30, 6'd20, 6'd10, 6'd50, 6'd50, 32'h0002_0000},
    '{KIND_INACCESS, 6'd32, 6'd32, 6'd31, 6'd0,  6'd63, 6'd63, 32'h7fff_0000},
    '{KIND_CIRCLE,   6'd5,  6'd5,  6'd10, 6'd0,  6'd50, 6'd50, 32'h0003_0000},
    '{KIND_LAST_UNUSED, 6'd63, 6'd63, 6'd63, 6'd63, 6'd1, 6'd1, 32'h5555_aaaa}
  };

  probe_pair_t directed_probes [DIRECTED] = '{
    '{6'd10, 6'd10, 6'd63, 6'd63},
    '{6'd20, 6'd25, 6'd20, 6'd15},
    '{6'd20, 6'd15, 6'd0,  6'd0},
    '{6'd25, 6'd30, 6'd15, 6'd30},
    '{6'd15, 6'd30, 6'd25, 6'd30},
    '{6'd5,  6'd3,  6'd41, 6'd10},
    '{6'd20, 6'd24, 6'd10, 6'd5},
    '{6'd20, 6'd21, 6'd63, 6'd0},
    '{6'd50, 6'd30, 6'd30, 6'd41},
    '{6'd32, 6'd32, 6'd0,  6'd32},
    '{6'd5,  6'd5,  6'd0,  6'd63},
    '{6'd0,  6'd0,  6'd63, 6'd63}
  };

  always #2 clk = ~clk;

  grid_cell_shape_membership_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x       (out_x),
    .out_y       (out_y),
    .mark        (mark),
    .write_value (write_value),
    .shape_fits  (shape_fits)
  );

  gcsm_cover_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x       (out_x),
    .out_y       (out_y),
    .mark        (mark),
    .write_value (write_value),
    .shape_fits  (shape_fits),
    .fault_count (fault_count),
    .outstanding (outstanding)
  );

  // The result side stalls about a third of the time unless stalls are off.
  always @(posedge clk) begin
    out_ready <= stalls_on ? ($urandom_range(99) >= 35) : 1'b1;
  end

  // Hang detector: any accepted word on any channel restarts the count.
  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("grid_cell_shape_membership_core test failed");
        $finish;
      end
    end
  end

  // Returns a value in lo..hi, landing on either end now and then.
  function automatic int pick_coord(int lo, int hi);
    case ($urandom_range(9))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // Most random shapes are built to fit their grid, so that coverage is
  // really exercised; the rest take arbitrary values and often do not fit.
  function automatic shape_setup_t random_setup();
    shape_setup_t s;
    int gx, gy, rx, ry;
    if ($urandom_range(99) < 8) begin
      s.kind = KIND_W'($urandom_range(KIND_LAST_UNUSED, KIND_FIRST_UNUSED));
    end else begin
      s.kind = KIND_W'($urandom_range(KIND_INACCESS, KIND_CIRCLE));
    end
    gx = pick_coord(1, COORD_MAX);
    gy = pick_coord(1, COORD_MAX);
    s.gx = COORD_W'(gx);
    s.gy = COORD_W'(gy);
    case ($urandom_range(9))
      0: s.fill = 32'h7fff_ffff;
      1: s.fill = 32'h8000_0000;
      default: s.fill = $urandom();
    endcase
    s.p1 = COORD_W'(pick_coord(0, COORD_MAX));
    s.p2 = COORD_W'(pick_coord(0, COORD_MAX));
    s.p3 = COORD_W'(pick_coord(0, COORD_MAX));
    s.p4 = COORD_W'(pick_coord(0, COORD_MAX));
    if ($urandom_range(3) != 0) begin
      if (s.kind == KIND_RECT || s.kind == KIND_TRIANGLE) begin
        s.p1 = COORD_W'(pick_coord(0, gx));
        s.p2 = COORD_W'(pick_coord(0, gx));
        s.p3 = COORD_W'(pick_coord(0, gy));
        s.p4 = COORD_W'(pick_coord(0, gy));
      end else if (s.kind == KIND_ELLIPSE) begin
        rx = $urandom_range(gx / 2);
        ry = $urandom_range(gy / 2);
        s.p1 = COORD_W'($urandom_range(gx - rx, rx));
        s.p2 = COORD_W'($urandom_range(gy - ry, ry));
        s.p3 = COORD_W'(rx);
        s.p4 = COORD_W'(ry);
      end else if (s.kind <= KIND_HALF_W || s.kind == KIND_INACCESS) begin
        rx = $urandom_range(((gx < gy) ? gx : gy) / 2);
        s.p1 = COORD_W'($urandom_range(gx - rx, rx));
        s.p2 = COORD_W'($urandom_range(gy - rx, rx));
        s.p3 = COORD_W'(rx);
      end
    end
    return s;
  endfunction

  // Picks a cell mostly around the given box, sometimes anywhere.
  function automatic logic [COORD_W-1:0] aim_coord(int lo, int hi);
    if ($urandom_range(4) == 0) return COORD_W'($urandom_range(COORD_MAX));
    lo = (lo - 2 < 0) ? 0 : lo - 2;
    hi = (hi + 2 > COORD_MAX) ? COORD_MAX : hi + 2;
    if (lo > hi) lo = hi;
    return COORD_W'($urandom_range(hi, lo));
  endfunction

  // Writes all eight registers back to back. Bits above a register's width
  // are filled with junk at times, since the core must ignore them.
  task automatic load_shape(input shape_setup_t s);
    logic [VALUE_W-1:0] vals [REG_FILL+1];
    logic [VALUE_W-1:0] data;
    bit ok;
    vals[REG_SHAPE_KIND] = VALUE_W'(s.kind);
    vals[REG_CX_X1] = VALUE_W'(s.p1);
    vals[REG_CY_X2] = VALUE_W'(s.p2);
    vals[REG_R_Y1] = VALUE_W'(s.p3);
    vals[REG_EXTRA_Y2] = VALUE_W'(s.p4);
    vals[REG_GRID_X] = VALUE_W'(s.gx);
    vals[REG_GRID_Y] = VALUE_W'(s.gy);
    vals[REG_FILL] = s.fill;
    for (int i = 0; i <= int'(REG_FILL); i++) begin
      data = vals[i];
      if (i != int'(REG_FILL) && $urandom_range(3) == 0) begin
        data = data | (VALUE_W'($urandom()) <<
                       ((i == int'(REG_SHAPE_KIND)) ? KIND_W : COORD_W));
      end
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= data;
      do begin
        @(negedge clk);
        ok = cfg_ready;
        @(posedge clk);
      end while (!ok);
    end
    cfg_valid <= 1'b0;
  endtask

  // Offers one cell word, after a random gap when gaps are on. The valid is
  // left high afterward so back-to-back words need no extra assignment.
  task automatic send_cell(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    bit ok;
    while (gaps_on && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_x <= x;
    cell_y <= y;
    do begin
      @(negedge clk);
      ok = in_ready;
      @(posedge clk);
    end while (!ok);
  endtask

  // Stops sending and waits until every predicted result word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    shape_setup_t s;
    int a, b, c, d, xlo, xhi, ylo, yhi;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed shapes, each with its two probe cells.
    for (int n = 0; n < DIRECTED; n++) begin
      load_shape(directed_plan[n]);
      send_cell(directed_probes[n].x0, directed_probes[n].y0);
      send_cell(directed_probes[n].x1, directed_probes[n].y1);
      wait_drained();
    end

    // Random shapes. A few phases in the middle run with no gaps and no
    // stalls at all, so the pipeline also sees a full-rate stream.
    for (int p = 0; p < PHASES; p++) begin
      s = random_setup();
      gaps_on = !(p >= 6 && p <= 8);
      stalls_on = gaps_on;
      load_shape(s);
      a = s.p1;
      b = s.p2;
      c = s.p3;
      d = s.p4;
      if (s.kind <= KIND_HALF_W || s.kind == KIND_INACCESS) begin
        xlo = a - c;
        xhi = a + c;
        ylo = b - c;
        yhi = b + c;
      end else if (s.kind == KIND_RECT || s.kind == KIND_TRIANGLE) begin
        xlo = (a < b) ? a : b;
        xhi = (a > b) ? a : b;
        ylo = (c < d) ? c : d;
        yhi = (c > d) ? c : d;
      end else if (s.kind == KIND_ELLIPSE) begin
        xlo = a - c;
        xhi = a + c;
        ylo = b - d;
        yhi = b + d;
      end else begin
        xlo = 0;
        xhi = COORD_MAX;
        ylo = 0;
        yhi = COORD_MAX;
      end
      for (int k = 0; k < PHASE_CELLS; k++) begin
        send_cell(aim_coord(xlo, xhi), aim_coord(ylo, yhi));
        // Once mid-phase, hold off the sender until the core has emptied.
        if (p == 3 && k == PHASE_CELLS / 2) wait_drained();
      end
      wait_drained();
    end

    // Leave room for any stray result word to show up before the verdict.
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("grid_cell_shape_membership_core test passed");
    end else begin
      $display("grid_cell_shape_membership_core test failed");
    end
    $finish;
  end

endmodule
